/* src/sacnru_pkg.sv */
package sacnru_pkg;

	localparam int TAG_W      = 32;
	localparam int IN_ADDR_W  = 32;
	localparam int ABITS_W    = 6;
	localparam int OFFSET_W   = 5;
	localparam int INDEX_W    = 4;
	localparam int WAYCFG_W   = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;
	localparam int WAY_OUT_W  = 3;
	localparam int CNT_W      = 32;
	localparam int SETF_W     = 16;

	typedef logic [TAG_W-1:0]     tag_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_ADDRESS_BITS = 2'd0;
	localparam cfg_idx_t CFG_OFFSET_BITS  = 2'd1;
	localparam cfg_idx_t CFG_INDEX_BITS   = 2'd2;
	localparam cfg_idx_t CFG_WAYS_IN_USE  = 2'd3;

	localparam logic [ABITS_W-1:0]  RST_ADDRESS_BITS = 6'd32;
	localparam logic [OFFSET_W-1:0] RST_OFFSET_BITS  = 5'd2;
	localparam logic [INDEX_W-1:0]  RST_INDEX_BITS   = 4'd8;
	localparam logic [WAYCFG_W-1:0] RST_WAYS_IN_USE  = 4'd8;

	// one way of a set: valid mark, not-recently-used bit, tag
	typedef struct packed {
		logic valid;
		logic nru;
		tag_t tag;
	} entry_t;

endpackage

/* src/sacnru_lookup.sv */
module sacnru_lookup #(
	parameter int WAYS  = 8,
	parameter int WAY_W = 3,
	parameter int NW_W  = 4
) (
	input  logic [NW_W-1:0]                nways,
	input  sacnru_pkg::tag_t               tag,
	input  sacnru_pkg::entry_t [WAYS-1:0]  row_in,
	output logic                           hit,
	output logic [WAY_W-1:0]               way,
	output sacnru_pkg::entry_t [WAYS-1:0]  row_out
);
	import sacnru_pkg::*;

	logic [WAYS-1:0] in_use;
	logic            found;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			in_use[w] = (NW_W'(w) < nways);
		end
	end

	always_comb begin
		row_out = row_in;
		hit     = 1'b0;
		found   = 1'b0;
		way     = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (!hit && in_use[w] && row_in[w].valid && row_in[w].tag == tag) begin
				hit = 1'b1;
				way = WAY_W'(w);
			end
		end
		if (!hit) begin
			for (int w = 0; w < WAYS; w++) begin
				if (!found && in_use[w] && row_in[w].nru) begin
					found = 1'b1;
					way   = WAY_W'(w);
				end
			end
			// no candidate: re-arm every way in use, victim is way 0
			if (!found) begin
				for (int w = 0; w < WAYS; w++) begin
					if (in_use[w]) begin
						row_out[w].nru = 1'b1;
					end
				end
			end
			row_out[way].tag   = tag;
			row_out[way].valid = 1'b1;
		end
		row_out[way].nru = 1'b0;
	end

endmodule

/* src/set_assoc_cache_nru_replacement.sv */
// Set-associative cache lookup with not-recently-used replacement.
// Request channel (req_valid/req_stall) carries one byte address per
// transaction; the response channel (rsp_valid/rsp_stall) returns hit, the
// way that hit or was filled, and the saturating miss count after the access.
// Configuration (address, offset and index widths, ways in use) is written
// through cfg_valid/cfg_ready/cfg_index/cfg_data, by the user only while the
// block is idle, which the block itself leaves unchecked; cfg_ready is always high.
// The accepting edge reads the set row from the tag memory into the stage-1
// register. The response register is loaded from stage 1 when it advances,
// after one pass of hit detection, victim choice and the row update. One
// request per cycle is sustained while the response side is not stalled.
// Back-to-back requests to the same set take the updated row from a
// forwarding register.
// When rsp_stall is high with a response pending, stage 1 holds and req_stall
// rises while stage 1 is occupied.
// Reset clears the per-set row-valid flops, so every set reads as all ways
// invalid with NRU bits set; the memory itself needs no clearing pass. The
// miss counter resets to zero and configuration returns to its defaults.
// SETS must be a power of two.
module set_assoc_cache_nru_replacement #(
	parameter int SETS       = 256,
	parameter int WAYS       = 8,
	parameter int ADDR_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [sacnru_pkg::IN_ADDR_W-1:0]   address,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic                               hit,
	output logic [sacnru_pkg::WAY_OUT_W-1:0]   way_used,
	output logic [sacnru_pkg::CNT_W-1:0]       miss_total,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  sacnru_pkg::cfg_idx_t               cfg_index,
	input  logic [sacnru_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import sacnru_pkg::*;

	localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int NW_W      = $clog2(WAYS + 1);
	localparam int ABITS_MAX = (ADDR_WIDTH > 32) ? 32 : ADDR_WIDTH;

	typedef entry_t [WAYS-1:0] row_t;

	logic [ABITS_W-1:0]  addr_bits_q;
	logic [OFFSET_W-1:0] offset_bits_q;
	logic [INDEX_W-1:0]  index_bits_q;
	logic [WAYCFG_W-1:0] ways_q;

	logic [ABITS_W-1:0]   abits;
	logic [IN_ADDR_W-1:0] addr_m;
	logic [SETF_W-1:0]    set_field;
	logic [SET_W-1:0]     set_in;
	tag_t                 tag_in;
	logic [NW_W-1:0]      nways;

	logic accept, advance, commit;

	row_t             tag_mem [SETS];
	logic [SETS-1:0]  row_valid_q;
	logic             valid_s1;
	logic [SET_W-1:0] set_s1;
	tag_t             tag_s1;
	row_t             row_s1;
	logic             bypass_s1;
	row_t             fwd_row_s1;
	row_t             reset_row;
	row_t             cur_row;
	row_t             new_row;
	logic             lk_hit;
	logic [WAY_W-1:0] lk_way;

	logic [CNT_W-1:0]     miss_cnt_q;
	logic [CNT_W-1:0]     miss_next;
	logic                 rsp_valid_s2;
	logic                 hit_s2;
	logic [WAY_OUT_W-1:0] way_s2;
	logic [CNT_W-1:0]     miss_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_bits_q   <= RST_ADDRESS_BITS;
			offset_bits_q <= RST_OFFSET_BITS;
			index_bits_q  <= RST_INDEX_BITS;
			ways_q        <= RST_WAYS_IN_USE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ADDRESS_BITS: addr_bits_q   <= cfg_data[ABITS_W-1:0];
				CFG_OFFSET_BITS:  offset_bits_q <= cfg_data[OFFSET_W-1:0];
				CFG_INDEX_BITS:   index_bits_q  <= cfg_data[INDEX_W-1:0];
				CFG_WAYS_IN_USE:  ways_q        <= cfg_data[WAYCFG_W-1:0];
				default: ;
			endcase
		end
	end

	// address split
	always_comb begin
		abits = (addr_bits_q > ABITS_W'(ABITS_MAX)) ? ABITS_W'(ABITS_MAX) : addr_bits_q;
		addr_m = address & IN_ADDR_W'((33'd1 << abits) - 33'd1);
		set_field = SETF_W'(addr_m >> offset_bits_q)
			& SETF_W'((17'd1 << index_bits_q) - 17'd1);
		set_in = (SETS == 1) ? '0 : SET_W'(set_field);
		tag_in = tag_t'(addr_m >> (ABITS_W'(offset_bits_q) + ABITS_W'(index_bits_q)));
	end

	always_comb begin
		if (ways_q == '0) begin
			nways = NW_W'(1);
		end else if (32'(ways_q) > 32'(WAYS)) begin
			nways = NW_W'(WAYS);
		end else begin
			nways = NW_W'(ways_q);
		end
	end

	assign advance   = !rsp_valid_s2 || !rsp_stall;
	assign req_stall = valid_s1 && !advance;
	assign accept    = req_valid && !req_stall;
	assign commit    = valid_s1 && advance;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			reset_row[w].valid = 1'b0;
			reset_row[w].nru   = 1'b1;
			reset_row[w].tag   = '0;
		end
	end

	always_comb begin
		if (bypass_s1) begin
			cur_row = fwd_row_s1;
		end else if (row_valid_q[set_s1]) begin
			cur_row = row_s1;
		end else begin
			cur_row = reset_row;
		end
	end

	sacnru_lookup #(
		.WAYS  (WAYS),
		.WAY_W (WAY_W),
		.NW_W  (NW_W)
	) u_lookup (
		.nways   (nways),
		.tag     (tag_s1),
		.row_in  (cur_row),
		.hit     (lk_hit),
		.way     (lk_way),
		.row_out (new_row)
	);

	assign miss_next = (!lk_hit && miss_cnt_q != '1) ? miss_cnt_q + CNT_W'(1) : miss_cnt_q;

	// tag memory and stage-1 payload; a read that coincides with a write to
	// the same set returns the old row, so the new row is forwarded instead
	always_ff @(posedge clk) begin
		if (commit) begin
			tag_mem[set_s1] <= new_row;
		end
		if (accept) begin
			row_s1     <= tag_mem[set_in];
			set_s1     <= set_in;
			tag_s1     <= tag_in;
			fwd_row_s1 <= new_row;
		end
		if (commit) begin
			hit_s2  <= lk_hit;
			way_s2  <= WAY_OUT_W'(lk_way);
			miss_s2 <= miss_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			bypass_s1    <= 1'b0;
			row_valid_q  <= '0;
			miss_cnt_q   <= '0;
			rsp_valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1  <= 1'b1;
				bypass_s1 <= commit && (set_s1 == set_in);
			end else if (advance) begin
				valid_s1  <= 1'b0;
				bypass_s1 <= 1'b0;
			end
			if (commit) begin
				row_valid_q[set_s1] <= 1'b1;
				miss_cnt_q          <= miss_next;
			end
			if (advance) begin
				rsp_valid_s2 <= valid_s1;
			end
		end
	end

	assign rsp_valid  = rsp_valid_s2;
	assign hit        = hit_s2;
	assign way_used   = way_s2;
	assign miss_total = miss_s2;

	a_miss_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> miss_cnt_q >= $past(miss_cnt_q))
		else $error("miss counter decreased");

	a_hit_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		commit && lk_hit |=> miss_cnt_q == $past(miss_cnt_q))
		else $error("miss counter changed on a hit");

	a_bypass_needs_stage: assert property (@(posedge clk) disable iff (!arst_n)
		bypass_s1 |-> valid_s1)
		else $error("forwarding flag set with stage 1 empty");

	a_stall_needs_stage: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && rsp_valid_s2)
		else $error("request stalled without a blocked stage");

	a_used_way_updated: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> new_row[lk_way].valid && !new_row[lk_way].nru && new_row[lk_way].tag == tag_s1)
		else $error("used way not left valid and recently used");

endmodule

/* verif/tb_set_assoc_cache_nru_replacement.sv */
module tb_set_assoc_cache_nru_replacement;
	import sacnru_pkg::*;

	localparam int N_SETS = 256;
	localparam int N_WAYS = 8;
	localparam int ADDR_W = 32;

	typedef struct packed {
		logic                 hit;
		logic [WAY_OUT_W-1:0] way;
		logic [CNT_W-1:0]     misses;
	} lookup_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	logic [IN_ADDR_W-1:0]  address   = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	logic                  hit;
	logic [WAY_OUT_W-1:0]  way_used;
	logic [CNT_W-1:0]      miss_total;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_idx_t              cfg_index = CFG_ADDRESS_BITS;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// shadow copy of the cache: configuration, tags, valid marks, NRU bits, miss count
	logic [ABITS_W-1:0]  cur_abits  = RST_ADDRESS_BITS;
	logic [OFFSET_W-1:0] cur_offset = RST_OFFSET_BITS;
	logic [INDEX_W-1:0]  cur_index  = RST_INDEX_BITS;
	logic [WAYCFG_W-1:0] cur_ways   = RST_WAYS_IN_USE;
	tag_t                tag_mem   [N_SETS][N_WAYS];
	logic [N_WAYS-1:0]   valid_mem [N_SETS];
	logic [N_WAYS-1:0]   nru_mem   [N_SETS];
	logic [CNT_W-1:0]    miss_count = '0;

	lookup_t     pending_q[$];
	int unsigned sent_count    = 0;
	int unsigned resp_count    = 0;
	int unsigned fail_count    = 0;
	int unsigned send_idle_pct = 0;
	int unsigned rsp_stall_pct = 0;
	int unsigned hold_len      = 0;
	int unsigned hold_cnt      = 0;

	set_assoc_cache_nru_replacement #(
		.SETS       (N_SETS),
		.WAYS       (N_WAYS),
		.ADDR_WIDTH (ADDR_W)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.address    (address),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.hit        (hit),
		.way_used   (way_used),
		.miss_total (miss_total),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("tb_set_assoc_cache_nru_replacement NOT OK");
		$finish;
	end

	// Lookup plus NRU update of the shadow cache for one address.
	function automatic lookup_t predict_lookup(input logic [IN_ADDR_W-1:0] a);
		int unsigned eff_bits, off, idx, nways, set_i, w, hw;
		logic [63:0] masked, set_field;
		tag_t        tg;
		lookup_t     r;
		bit          found, placed;
		eff_bits = (cur_abits > ADDR_W) ? ADDR_W : 32'(cur_abits);
		if (eff_bits > IN_ADDR_W)
			eff_bits = IN_ADDR_W;
		off = 32'(cur_offset);
		idx = 32'(cur_index);
		masked = 64'(a) & ((64'd1 << eff_bits) - 64'd1);
		set_field = (masked >> off) & ((64'd1 << idx) - 64'd1);
		set_i = int'(set_field % N_SETS);
		tg = tag_t'(masked >> (off + idx));
		nways = (cur_ways == 0) ? 1 : ((cur_ways > N_WAYS) ? N_WAYS : 32'(cur_ways));
		found = 1'b0;
		placed = 1'b0;
		hw = 0;
		for (w = 0; w < nways && !found; w++) begin
			if (valid_mem[set_i][w] && tag_mem[set_i][w] == tg) begin
				found = 1'b1;
				hw = w;
			end
		end
		if (!found) begin
			if (miss_count != '1)
				miss_count++;
			for (w = 0; w < nways && !placed; w++) begin
				if (nru_mem[set_i][w]) begin
					placed = 1'b1;
					hw = w;
				end
			end
			// nobody left to evict: re-arm the whole set, fall back to way 0
			if (!placed) begin
				for (w = 0; w < nways; w++)
					nru_mem[set_i][w] = 1'b1;
				hw = 0;
			end
			tag_mem[set_i][hw] = tg;
			valid_mem[set_i][hw] = 1'b1;
		end
		nru_mem[set_i][hw] = 1'b0;
		r.hit = found;
		r.way = hw[WAY_OUT_W-1:0];
		r.misses = miss_count;
		return r;
	endfunction

	task automatic log_failure(input string text);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", text);
	endtask

	always @(posedge clk) begin
		lookup_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				resp_count++;
				if (pending_q.size() == 0) begin
					log_failure($sformatf("%0t: response with no request pending", $time));
				end else begin
					want = pending_q.pop_front();
					if (hit !== want.hit || way_used !== want.way ||
					    miss_total !== want.misses)
						log_failure($sformatf(
							"%0t: expected hit=%0b way=%0d miss_total=%0d, got hit=%0b way=%0d miss_total=%0d",
							$time, want.hit, want.way, want.misses,
							hit, way_used, miss_total));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ADDRESS_BITS: cur_abits  = cfg_data[ABITS_W-1:0];
					CFG_OFFSET_BITS:  cur_offset = cfg_data[OFFSET_W-1:0];
					CFG_INDEX_BITS:   cur_index  = cfg_data[INDEX_W-1:0];
					CFG_WAYS_IN_USE:  cur_ways   = cfg_data[WAYCFG_W-1:0];
					default: ;
				endcase
			end
			if (req_valid && !req_stall)
				pending_q = {pending_q, predict_lookup(address)};
		end
	end

	// response-side stall; held high while hold_cnt trails hold_len, else drawn at random
	always @(posedge clk) begin
		if (hold_cnt < hold_len) begin
			rsp_stall <= 1'b1;
			hold_cnt <= hold_cnt + 1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
		end
	end

	task automatic send_address(input logic [IN_ADDR_W-1:0] a);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		address <= a;
		do @(posedge clk); while (req_stall);
		sent_count++;
	endtask

	task automatic drain_responses();
		req_valid <= 1'b0;
		while (resp_count < sent_count)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] ab, input logic [CFG_DATA_W-1:0] off,
	                          input logic [CFG_DATA_W-1:0] idx, input logic [CFG_DATA_W-1:0] wy);
		cfg_idx_t              regs [4];
		logic [CFG_DATA_W-1:0] vals [4];
		drain_responses();
		regs[0] = CFG_ADDRESS_BITS;
		regs[1] = CFG_OFFSET_BITS;
		regs[2] = CFG_INDEX_BITS;
		regs[3] = CFG_WAYS_IN_USE;
		vals[0] = ab;
		vals[1] = off;
		vals[2] = idx;
		vals[3] = wy;
		for (int k = 0; k < 4; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[k];
			cfg_data <= vals[k];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// Mostly a handful of tags over a few sets so hits and evictions happen.
	function automatic logic [IN_ADDR_W-1:0] pick_address();
		int unsigned off, idx;
		logic [63:0] a;
		if ($urandom_range(0, 99) < 25)
			return $urandom();
		off = 32'(cur_offset);
		idx = 32'(cur_index);
		a = (64'($urandom_range(0, 11)) << (off + idx))
		  | (64'($urandom_range(0, 3)) << off)
		  | (64'($urandom()) & ((64'd1 << off) - 64'd1));
		return a[IN_ADDR_W-1:0];
	endfunction

	task automatic test_directed_lookups();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		send_address(32'h0000_0000);
		send_address(32'h0000_0003);
		send_address(32'hFFFF_FFFF);
		// fill set 0; the last of these tags finds no NRU candidate and forces the re-arm
		for (int t = 1; t <= 8; t++)
			send_address(t << 10);
		send_address(32'd3 << 10);
		send_address(32'h0000_0000);
		drain_responses();
	endtask

	task automatic test_config_corners();
		// no meaningful address bits
		set_config(0, 2, 8, 8);
		send_address(32'hFFFF_FFFF);
		send_address(32'h1234_5678);
		// oversized address width, fields past the top, zero ways
		set_config(63, 31, 15, 0);
		send_address(32'h8000_0000);
		send_address(32'h7FFF_FFFF);
		send_address(32'hFFFF_FFFF);
		// one address bit, offset past the top, no index, too many ways
		set_config(1, 63, 0, 15);
		send_address(32'h0000_0000);
		send_address(32'h0000_0001);
		send_address(32'hFFFF_FFFE);
		send_address(32'h0000_0003);
		drain_responses();
	endtask

	task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
		int unsigned ab, off, idx, wy;
		for (int round = 0; round < 2; round++) begin
			case ($urandom_range(0, 3))
				0: ab = 32;
				1: ab = $urandom_range(0, 63);
				2: ab = $urandom_range(12, 31);
				default: ab = 63;
			endcase
			off = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 5);
			idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
			wy = $urandom_range(0, 15);
			set_config(CFG_DATA_W'(ab), CFG_DATA_W'(off), CFG_DATA_W'(idx), CFG_DATA_W'(wy));
			send_idle_pct = idle_pct;
			rsp_stall_pct = stall_pct;
			repeat (188) send_address(pick_address());
			drain_responses();
			send_idle_pct = 0;
			rsp_stall_pct = 0;
		end
	endtask

	task automatic test_fill_under_stall();
		set_config(CFG_DATA_W'(RST_ADDRESS_BITS), CFG_DATA_W'(RST_OFFSET_BITS),
		           CFG_DATA_W'(RST_INDEX_BITS), CFG_DATA_W'(RST_WAYS_IN_USE));
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		hold_len <= hold_len + 200;
		repeat (40) send_address(pick_address());
		drain_responses();
	endtask

	initial begin
		for (int s = 0; s < N_SETS; s++) begin
			valid_mem[s] = '0;
			nru_mem[s] = '1;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_lookups();
		test_config_corners();
		test_random_traffic(0, 0);
		test_random_traffic(67, 0);
		test_random_traffic(0, 67);
		test_random_traffic(12, 12);
		test_fill_under_stall();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("tb_set_assoc_cache_nru_replacement OK");
		else
			$display("tb_set_assoc_cache_nru_replacement NOT OK");
		$finish;
	end

endmodule
